FILE: rtl/grid_neighbour_index_defines.svh
// assertion macros for the grid neighbour index block
`ifndef GRID_NEIGHBOUR_INDEX_DEFINES_SVH
`define GRID_NEIGHBOUR_INDEX_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define GNI_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define GNI_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gni_pkg.sv
// shared types, constants and lookup functions for the grid neighbour index block
package gni_pkg;

  localparam int LOC_W      = 20;
  localparam int DIR_W      = 3;
  localparam int BC_W       = 4;
  localparam int KIND_W     = 2;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CELLS_W    = 21;
  localparam int OFF_W      = 22;
  localparam int REM_W      = DIM_W;
  localparam int DIV_STAGES = LOC_W;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
  localparam logic [DIM_W-1:0] MIN_DIM    = 11'd2;
  localparam logic [DIM_W-1:0] RESET_DIM  = 11'd64;

  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ORTHO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [BC_W-1:0] BC_NONE        = 4'd0;
  localparam logic [BC_W-1:0] BC_TOP         = 4'd1;
  localparam logic [BC_W-1:0] BC_BOTTOM      = 4'd2;
  localparam logic [BC_W-1:0] BC_LEFT        = 4'd4;
  localparam logic [BC_W-1:0] BC_RIGHT       = 4'd8;
  localparam logic [BC_W-1:0] BC_HEX_ODD_INT = 4'd11;

  localparam logic signed [OFF_W-1:0] ONE_S = 22'sd1;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic [DIR_W-1:0] direction;
  } gni_in_t;

  typedef struct packed {
    logic [LOC_W-1:0] neighbour;
    logic             valid_res;
    logic [BC_W-1:0]  boundary_class;
  } gni_out_t;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic [DIR_W-1:0] direction;
    logic             in_range;
  } gni_side_t;

  typedef struct packed {
    logic [LOC_W-1:0] location;
    logic [DIR_W-1:0] direction;
    logic [BC_W-1:0]  bc;
    logic             go;
    logic             odd;
  } gni_cls_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CELLS_W-1:0] cells;
  } gni_cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) begin
      r = MIN_DIM;
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  function automatic logic [7:0] dir_mask(input logic [KIND_W-1:0] kind,
                                          input logic [BC_W-1:0] bc);
    logic [7:0] m;
    m = 8'h00;
    if (kind == KIND_SQUARE) begin
      case (bc)
        4'd0:    m = 8'hFF;
        4'd1:    m = 8'h7C;
        4'd2:    m = 8'hC7;
        4'd4:    m = 8'h1F;
        4'd5:    m = 8'h1C;
        4'd6:    m = 8'h07;
        4'd8:    m = 8'hF1;
        4'd9:    m = 8'h70;
        4'd10:   m = 8'hC1;
        default: m = 8'h00;
      endcase
    end else if (kind == KIND_ORTHO) begin
      case (bc)
        4'd0:    m = 8'h0F;
        4'd1:    m = 8'h0E;
        4'd2:    m = 8'h0B;
        4'd4:    m = 8'h07;
        4'd5:    m = 8'h06;
        4'd6:    m = 8'h03;
        4'd8:    m = 8'h0D;
        4'd9:    m = 8'h0C;
        4'd10:   m = 8'h09;
        default: m = 8'h00;
      endcase
    end else if (kind == KIND_HEX) begin
      case (bc)
        4'd0:    m = 8'h3F;
        4'd1:    m = 8'h1E;
        4'd2:    m = 8'h33;
        4'd3:    m = 8'h07;
        4'd4:    m = 8'h2F;
        4'd5:    m = 8'h0E;
        4'd6:    m = 8'h03;
        4'd7:    m = 8'h3D;
        4'd8:    m = 8'h38;
        4'd9:    m = 8'h18;
        4'd10:   m = 8'h31;
        4'd11:   m = 8'h3F;
        default: m = 8'h00;
      endcase
    end
    return m;
  endfunction

  function automatic logic signed [OFF_W-1:0] dir_offset(input logic [KIND_W-1:0] kind,
                                                         input logic odd,
                                                         input logic [DIR_W-1:0] dir,
                                                         input logic [DIM_W-1:0] w);
    logic signed [OFF_W-1:0] ws;
    logic signed [OFF_W-1:0] o;
    ws = signed'(OFF_W'(w));
    o  = '0;
    if (kind == KIND_SQUARE) begin
      case (dir)
        3'd0:    o = -ws;
        3'd1:    o = -ws + ONE_S;
        3'd2:    o = ONE_S;
        3'd3:    o = ws + ONE_S;
        3'd4:    o = ws;
        3'd5:    o = ws - ONE_S;
        3'd6:    o = -ONE_S;
        default: o = -ws - ONE_S;
      endcase
    end else if (kind == KIND_ORTHO) begin
      case (dir[1:0])
        2'd0:    o = -ws;
        2'd1:    o = ONE_S;
        2'd2:    o = ws;
        default: o = -ONE_S;
      endcase
    end else if (odd) begin
      case (dir)
        3'd0:    o = -ws;
        3'd1:    o = ONE_S;
        3'd2:    o = ws;
        3'd3:    o = ws - ONE_S;
        3'd4:    o = -ONE_S;
        3'd5:    o = -ws - ONE_S;
        default: o = '0;
      endcase
    end else begin
      case (dir)
        3'd0:    o = -ws + ONE_S;
        3'd1:    o = ONE_S;
        3'd2:    o = ws + ONE_S;
        3'd3:    o = ws;
        3'd4:    o = -ONE_S;
        3'd5:    o = -ws;
        default: o = '0;
      endcase
    end
    return o;
  endfunction

endpackage

FILE: rtl/gni_div.sv
// pipelined restoring divider, one quotient bit per stage, splits location into row and column
module gni_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  gni_pkg::gni_side_t     in_side,
  input  logic [gni_pkg::DIM_W-1:0] divisor,
  output logic                   out_v,
  output logic [gni_pkg::LOC_W-1:0] quotient,
  output logic [gni_pkg::REM_W-1:0] remainder,
  output gni_pkg::gni_side_t     out_side
);
  import gni_pkg::*;

  logic [DIV_STAGES-1:0] v_r;
  logic [REM_W-1:0]      rem_r   [DIV_STAGES];
  logic [LOC_W-1:0]      quo_r   [DIV_STAGES];
  logic [LOC_W-1:0]      dvd_r   [DIV_STAGES];
  gni_side_t             side_r  [DIV_STAGES];

  logic [REM_W-1:0]      rem_nxt [DIV_STAGES];
  logic [LOC_W-1:0]      quo_nxt [DIV_STAGES];
  logic [LOC_W-1:0]      dvd_nxt [DIV_STAGES];

  always_comb begin
    logic [REM_W-1:0] rem_p;
    logic [LOC_W-1:0] quo_p;
    logic [LOC_W-1:0] dvd_p;
    logic [REM_W:0]   rem_sh;
    logic [REM_W:0]   rem_sub;
    logic             ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem_p = '0;
        quo_p = '0;
        dvd_p = in_side.location;
      end else begin
        rem_p = rem_r[s-1];
        quo_p = quo_r[s-1];
        dvd_p = dvd_r[s-1];
      end
      rem_sh     = {rem_p, dvd_p[LOC_W-1]};
      ge         = rem_sh >= {1'b0, divisor};
      rem_sub    = rem_sh - {1'b0, divisor};
      rem_nxt[s] = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      quo_nxt[s] = {quo_p[LOC_W-2:0], ge};
      dvd_nxt[s] = {dvd_p[LOC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        side_r[s] <= (s == 0) ? in_side : side_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_v     = v_r[DIV_STAGES-1];
  assign quotient  = quo_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

FILE: rtl/gni_front.sv
// front end: accepts items, range check, row and column split, boundary classification
module gni_front (
  input  logic              clk,
  input  logic              rst_n,
  input  gni_pkg::gni_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  gni_pkg::gni_in_t  in_data,
  output logic              cls_valid,
  input  logic              cls_ready,
  output gni_pkg::gni_cls_t cls_data
);
  import gni_pkg::*;

  logic             adv;
  gni_side_t        side_in;
  logic             div_v;
  logic [LOC_W-1:0] row;
  logic [REM_W-1:0] col;
  gni_side_t        div_side;
  gni_cls_t         cls_nxt;
  logic             cls_v_r;
  gni_cls_t         cls_r;

  assign adv      = !cls_v_r || cls_ready;
  assign in_ready = adv;

  always_comb begin
    side_in.location  = in_data.location;
    side_in.direction = in_data.direction;
    side_in.in_range  = {1'b0, in_data.location} < cfg.cells;
  end

  gni_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (in_valid),
    .in_side   (side_in),
    .divisor   (cfg.width),
    .out_v     (div_v),
    .quotient  (row),
    .remainder (col),
    .out_side  (div_side)
  );

  always_comb begin
    logic [BC_W-1:0] base;
    logic [BC_W-1:0] bc;
    logic [7:0]      mask;
    logic            hex;
    hex  = cfg.kind == KIND_HEX;
    base = BC_NONE;
    if (col == '0) begin
      base = BC_LEFT;
    end else if (col == cfg.width - 11'd1) begin
      base = BC_RIGHT;
    end
    bc = base;
    if (row == '0) begin
      bc = base | BC_TOP;
    end else if (row == LOC_W'(cfg.height - 11'd1)) begin
      bc = base | BC_BOTTOM;
    end else if (hex && row[0]) begin
      bc = (base == BC_NONE) ? BC_HEX_ODD_INT : base - 4'd1;
    end
    if (!div_side.in_range) begin
      bc = BC_NONE;
    end
    mask              = dir_mask(cfg.kind, bc);
    cls_nxt.location  = div_side.location;
    cls_nxt.direction = div_side.direction;
    cls_nxt.bc        = bc;
    cls_nxt.go        = div_side.in_range && mask[div_side.direction];
    cls_nxt.odd       = hex && bc[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else if (adv) begin
      cls_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = cls_v_r;
  assign cls_data  = cls_r;

endmodule

FILE: rtl/gni_fifo.sv
// short queue between the classifying front end and the address back end
module gni_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  gni_pkg::gni_cls_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output gni_pkg::gni_cls_t pop_data
);
  import gni_pkg::*;

  gni_cls_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FIFO_CNT_W-1:0] cnt_nxt;
  logic                  push;
  logic                  pop;

  assign push_ready = cnt_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/gni_back.sv
// back end: neighbour offset, bounds check and output register
module gni_back (
  input  logic              clk,
  input  logic              rst_n,
  input  gni_pkg::gni_cfg_t cfg,
  input  logic              cls_valid,
  output logic              cls_ready,
  input  gni_pkg::gni_cls_t cls_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gni_pkg::gni_out_t out_data
);
  import gni_pkg::*;

  logic                    out_v_r;
  gni_out_t                out_r;
  gni_out_t                res_nxt;
  logic                    take;

  assign cls_ready = !out_v_r || out_ready;
  assign take      = cls_valid && cls_ready;

  always_comb begin
    logic signed [OFF_W-1:0] off;
    logic signed [OFF_W-1:0] n;
    logic                    ok;
    off = dir_offset(cfg.kind, cls_data.odd, cls_data.direction, cfg.width);
    n   = signed'(OFF_W'(cls_data.location)) + off;
    ok  = cls_data.go && (off != '0) && !n[OFF_W-1]
          && (n[OFF_W-2:0] < cfg.cells);
    res_nxt.neighbour      = ok ? n[LOC_W-1:0] : '0;
    res_nxt.valid_res      = ok;
    res_nxt.boundary_class = cls_data.bc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cls_ready) begin
      out_v_r <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/grid_neighbour_index.sv
// top level of the grid neighbour index block
// usage:
//   in_* channel carries one transaction per lookup: a linear cell index and a
//   direction. out_* returns one transaction per lookup, in order: neighbour
//   index, valid flag and boundary class. cfg_* writes grid kind (index 0),
//   width (1) and height (2); width and height are clamped to 2..1024 on write.
//   the user must write configuration only while no lookup is in flight;
//   the block does not enforce it, and cfg_ready is always high.
//   throughput: one transaction per cycle sustained, with no gaps, while the receiver does not stall.
//   an accepted lookup passes through the 20-stage divider that splits row and
//   column (its first stage loads at the accepting edge), then a classify
//   register, the queue and the output register.
//   when the receiver stalls, the output register holds, the two-entry queue
//   fills, then the whole front pipeline freezes and in_ready drops.
//   reset (rst_n low, synchronous) empties all stages and sets a square grid
//   of 64 by 64 cells.
module grid_neighbour_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gni_pkg::gni_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gni_pkg::gni_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gni_pkg::DIM_W-1:0]     cfg_data
);
  import gni_pkg::*;

  `include "grid_neighbour_index_defines.svh"

  logic [KIND_W-1:0] kind_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [2*DIM_W-1:0] area;
  gni_cfg_t          cfg;

  logic              front_v;
  logic              q_ready;
  gni_cls_t          front_d;
  logic              q_v;
  logic              back_ready;
  gni_cls_t          q_d;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_SQUARE;
      width_r  <= RESET_DIM;
      height_r <= RESET_DIM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KIND:   kind_r   <= cfg_data[KIND_W-1:0];
        CFG_WIDTH:  width_r  <= clamp_dim(cfg_data, MAX_WIDTH);
        CFG_HEIGHT: height_r <= clamp_dim(cfg_data, MAX_HEIGHT);
        default:    kind_r   <= kind_r;
      endcase
    end
  end

  assign area = width_r * height_r;

  always_comb begin
    cfg.kind   = kind_r;
    cfg.width  = width_r;
    cfg.height = height_r;
    cfg.cells  = area[CELLS_W-1:0];
  end

  gni_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (front_v),
    .cls_ready (q_ready),
    .cls_data  (front_d)
  );

  gni_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_v),
    .push_ready (q_ready),
    .push_data  (front_d),
    .pop_valid  (q_v),
    .pop_ready  (back_ready),
    .pop_data   (q_d)
  );

  gni_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cls_valid (q_v),
    .cls_ready (back_ready),
    .cls_data  (q_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `GNI_CHECK_NOW(a_invalid_is_zero, out_valid && !out_data.valid_res, out_data.neighbour == '0, "invalid result carries a nonzero neighbour")
  `GNI_CHECK_NOW(a_neighbour_in_grid, out_valid && out_data.valid_res, {1'b0, out_data.neighbour} < cfg.cells, "neighbour outside the grid")
  `GNI_CHECK_NOW(a_front_open_when_empty, !front_v, in_ready, "input stalled while the classify stage is empty")
  `GNI_CHECK_NEXT(a_front_holds_on_full, front_v && !q_ready, front_v && $stable(front_d), "classified item lost while the queue is full")

endmodule

FILE: verif/tb_grid_neighbour_index.sv
// testbench for grid_neighbour_index: directed and random lookups checked against a local predictor
module tb_grid_neighbour_index;
  timeunit 1ns;
  timeprecision 1ps;

  import gni_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RAND_PHASES     = 13;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  gni_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  gni_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KIND;
  logic [DIM_W-1:0]     cfg_data = '0;

  logic [KIND_W-1:0] grid_kind_q   = KIND_SQUARE;
  logic [DIM_W-1:0]  grid_width_q  = RESET_DIM;
  logic [DIM_W-1:0]  grid_height_q = RESET_DIM;

  gni_out_t    pending_neighbours[$];
  gni_out_t    want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        in_gaps_on = 1'b1;
  logic        out_stalls_on = 1'b1;

  grid_neighbour_index i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
    int d;
    d = int'(v);
    if (d < int'(MIN_DIM)) begin
      d = int'(MIN_DIM);
    end else if (d > int'(maxv)) begin
      d = int'(maxv);
    end
    return d;
  endfunction

  function automatic gni_out_t predict_neighbour(gni_in_t item);
    gni_out_t r;
    int w, h, loc, row, col, dr, dc, nr, nc;
    logic [BC_W-1:0] bc;
    logic dir_ok;
    r   = '0;
    w   = eff_dim(grid_width_q, MAX_WIDTH);
    h   = eff_dim(grid_height_q, MAX_HEIGHT);
    loc = int'(item.location);
    if (loc >= w * h) begin
      return r;
    end
    row = loc / w;
    col = loc % w;
    bc  = BC_NONE;
    if (col == 0) begin
      bc = BC_LEFT;
    end else if (col == w - 1) begin
      bc = BC_RIGHT;
    end
    if (row == 0) begin
      bc = bc + BC_TOP;
    end else if (row == h - 1) begin
      bc = bc + BC_BOTTOM;
    end else if (grid_kind_q == KIND_HEX && (row % 2) == 1) begin
      bc = (bc == BC_NONE) ? BC_HEX_ODD_INT : bc - 4'd1;
    end
    r.boundary_class = bc;

    // row and column step of each direction in each template
    dir_ok = 1'b1;
    dr = 0;
    dc = 0;
    case (grid_kind_q)
      KIND_SQUARE: begin
        case (item.direction)
          3'd0: begin dr = -1; dc = 0; end
          3'd1: begin dr = -1; dc = 1; end
          3'd2: begin dr = 0; dc = 1; end
          3'd3: begin dr = 1; dc = 1; end
          3'd4: begin dr = 1; dc = 0; end
          3'd5: begin dr = 1; dc = -1; end
          3'd6: begin dr = 0; dc = -1; end
          default: begin dr = -1; dc = -1; end
        endcase
      end
      KIND_ORTHO: begin
        case (item.direction)
          3'd0: begin dr = -1; dc = 0; end
          3'd1: begin dr = 0; dc = 1; end
          3'd2: begin dr = 1; dc = 0; end
          3'd3: begin dr = 0; dc = -1; end
          default: dir_ok = 1'b0;
        endcase
      end
      KIND_HEX: begin
        case (item.direction)
          3'd0: begin dr = -1; dc = 1; end
          3'd1: begin dr = 0; dc = 1; end
          3'd2: begin dr = 1; dc = 1; end
          3'd3: begin dr = 1; dc = 0; end
          3'd4: begin dr = 0; dc = -1; end
          3'd5: begin dr = -1; dc = 0; end
          default: dir_ok = 1'b0;
        endcase
        // odd rows and the bottom row sit half a cell to the left
        if (bc[1] && dr != 0) begin
          dc = dc - 1;
        end
      end
      default: dir_ok = 1'b0;
    endcase

    nr = row + dr;
    nc = col + dc;
    if (dir_ok && nr >= 0 && nr < h && nc >= 0 && nc < w) begin
      r.neighbour = LOC_W'(nr * w + nc);
      r.valid_res = 1'b1;
    end
    return r;
  endfunction

  function automatic int edge_heavy_pick(int n);
    int v;
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 1;
      2: v = n - 2;
      3: v = n - 1;
      default: v = $urandom_range(0, n - 1);
    endcase
    return v;
  endfunction

  function automatic logic [LOC_W-1:0] random_location();
    int w, h, cells;
    logic [LOC_W-1:0] loc;
    w     = eff_dim(grid_width_q, MAX_WIDTH);
    h     = eff_dim(grid_height_q, MAX_HEIGHT);
    cells = w * h;
    case ($urandom_range(0, 9))
      0: begin
        if (cells < (1 << LOC_W)) begin
          loc = LOC_W'($urandom_range(cells, (1 << LOC_W) - 1));
        end else begin
          loc = LOC_W'($urandom);
        end
      end
      1, 2: loc = LOC_W'($urandom_range(0, cells - 1));
      default: loc = LOC_W'(edge_heavy_pick(h) * w + edge_heavy_pick(w));
    endcase
    return loc;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    logic [DIM_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = DIM_W'($urandom_range(2, 12));
      6: begin
        case ($urandom_range(0, 5))
          0: d = 11'd0;
          1: d = 11'd1;
          2: d = 11'd2;
          3: d = 11'd1024;
          4: d = 11'd1025;
          default: d = 11'd2047;
        endcase
      end
      default: d = DIM_W'($urandom_range(0, 2047));
    endcase
    return d;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_neighbours.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_KIND:   grid_kind_q = value[KIND_W-1:0];
      CFG_WIDTH:  grid_width_q = value;
      CFG_HEIGHT: grid_height_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [KIND_W-1:0] kind, logic [DIM_W-1:0] w,
                           logic [DIM_W-1:0] h);
    write_reg(CFG_KIND, DIM_W'(kind));
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic send_lookup(logic [LOC_W-1:0] loc, logic [DIR_W-1:0] dir);
    gni_in_t item;
    int unsigned gap;
    item.location  = loc;
    item.direction = dir;
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_neighbours.push_back(predict_neighbour(item));
  endtask

  task automatic test_reset_defaults();
    send_lookup(20'd0, 3'd0);
    send_lookup(20'd0, 3'd3);
    send_lookup(20'd63, 3'd5);
    send_lookup(20'd4095, 3'd7);
    send_lookup(20'd4096, 3'd2);
    send_lookup(20'd2080, 3'd4);
  endtask

  task automatic test_orthogonal_grid();
    configure(KIND_ORTHO, 11'd5, 11'd4);
    send_lookup(20'd0, 3'd1);
    send_lookup(20'd7, 3'd3);
    send_lookup(20'd19, 3'd2);
    send_lookup(20'd6, 3'd5);
    send_lookup(20'd12, 3'd0);
  endtask

  task automatic test_hex_grid();
    configure(KIND_HEX, 11'd4, 11'd5);
    send_lookup(20'd5, 3'd5);
    send_lookup(20'd4, 3'd3);
    send_lookup(20'd7, 3'd1);
    send_lookup(20'd17, 3'd5);
    send_lookup(20'd9, 3'd6);
    send_lookup(20'd2, 3'd0);
  endtask

  task automatic test_size_clamping();
    configure(KIND_SQUARE, 11'd0, 11'd1);
    send_lookup(20'd3, 3'd7);
    send_lookup(20'd4, 3'd0);
    configure(KIND_SQUARE, 11'd2047, 11'd2047);
    send_lookup(20'hFFFFF, 3'd0);
    send_lookup(20'd1023, 3'd3);
  endtask

  task automatic test_unused_kind();
    configure(KIND_UNUSED, 11'd3, 11'd3);
    send_lookup(20'd4, 3'd0);
    send_lookup(20'd9, 3'd1);
  endtask

  task automatic test_random_lookups();
    logic [KIND_W-1:0] kind;
    int unsigned pick;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 3) ? KIND_SQUARE : (pick < 6) ? KIND_ORTHO :
             (pick < 9) ? KIND_HEX : KIND_UNUSED;
      if (ph == 0) begin
        configure(KIND_HEX, 11'd1024, 11'd1024);
      end else begin
        configure(kind, random_dim(), random_dim());
      end
      // no idling in the last phases
      in_gaps_on    = (ph < RAND_PHASES - 2) && (ph % 4 != 3);
      out_stalls_on = (ph < RAND_PHASES - 2) && (ph % 4 != 2);
      repeat (ITEMS_PER_PHASE) send_lookup(random_location(), DIR_W'($urandom_range(0, 7)));
    end
  endtask

  // receiver stalls
  always begin
    @(negedge clk);
    if (out_stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end else begin
      out_ready = 1'b1;
    end
  end

  // result check, one transaction per accepted output
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_neighbours.size() == 0) begin
        $error("unexpected result: neighbour %0d valid_res %0b boundary_class %0d",
               out_data.neighbour, out_data.valid_res, out_data.boundary_class);
        mismatch_count++;
      end else begin
        want = pending_neighbours.pop_front();
        if (out_data.neighbour !== want.neighbour) begin
          $error("neighbour: expected %0d, got %0d", want.neighbour, out_data.neighbour);
          mismatch_count++;
        end
        if (out_data.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0b, got %0b", want.valid_res, out_data.valid_res);
          mismatch_count++;
        end
        if (out_data.boundary_class !== want.boundary_class) begin
          $error("boundary_class: expected %0d, got %0d", want.boundary_class,
                 out_data.boundary_class);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_orthogonal_grid();
    test_hex_grid();
    test_size_clamping();
    test_unused_kind();
    test_random_lookups();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
